FILE: rtl/acc18_pkg.sv
// shared types, constants and order codes of the 18-bit accumulator executor
// no dependencies
`default_nettype none

package acc18_pkg;

	localparam int STORE_DEPTH_DEF = 8192;
	localparam int WORD_W          = 18;
	localparam int MADDR_W         = 16;
	localparam int DIV_STEPS       = 36;
	localparam int IN_TDATA_W      = 40;
	localparam int IN_TUSER_W      = 2;
	localparam int OUT_TDATA_W     = 72;

	// item kinds on tuser
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_EXEC  = 2'd2;

	// order functions
	localparam logic [3:0] F_LDB  = 4'd0;
	localparam logic [3:0] F_ADD  = 4'd1;
	localparam logic [3:0] F_NADD = 4'd2;
	localparam logic [3:0] F_STQ  = 4'd3;
	localparam logic [3:0] F_LDA  = 4'd4;
	localparam logic [3:0] F_STA  = 4'd5;
	localparam logic [3:0] F_AND  = 4'd6;
	localparam logic [3:0] F_JZ   = 4'd7;
	localparam logic [3:0] F_JMP  = 4'd8;
	localparam logic [3:0] F_JN   = 4'd9;
	localparam logic [3:0] F_INC  = 4'd10;
	localparam logic [3:0] F_STS  = 4'd11;
	localparam logic [3:0] F_MUL  = 4'd12;
	localparam logic [3:0] F_DIV  = 4'd13;
	localparam logic [3:0] F_SHF  = 4'd14;
	localparam logic [3:0] F_IO   = 4'd15;

	// fault codes
	localparam logic [2:0] FLT_NONE  = 3'd0;
	localparam logic [2:0] FLT_ADDR  = 3'd1;
	localparam logic [2:0] FLT_SHIFT = 3'd2;
	localparam logic [2:0] FLT_IO    = 3'd3;
	localparam logic [2:0] FLT_DIV0  = 3'd4;

	// fixed store words
	localparam logic [2:0] SC_L1 = 3'd0;
	localparam logic [2:0] BX_L1 = 3'd1;
	localparam logic [2:0] SC_L4 = 3'd6;
	localparam logic [2:0] BX_L4 = 3'd7;

	localparam logic [17:0] MOD_BITS     = 18'o160000;
	localparam logic [17:0] ADDR13       = 18'd8191;
	localparam logic [15:0] PROTECT_LOW  = 16'd8180;
	localparam logic [15:0] PROTECT_HIGH = 16'd8191;
	localparam logic [12:0] SHIFT_L_MAX  = 13'd2047;
	localparam logic [12:0] SHIFT_R_MIN  = 13'd6144;
	localparam logic [12:0] IO_RD_TAPE   = 13'd2048;
	localparam logic [12:0] IO_RD_TTY    = 13'd2052;
	localparam logic [12:0] IO_PUN_TAPE  = 13'd6144;
	localparam logic [12:0] IO_PUN_TTY   = 13'd6148;
	localparam logic [12:0] IO_LEVEL4    = 13'd7168;

	typedef struct packed {
		logic       busy;
		logic       done;
	} div_sts_t;

	typedef struct packed {
		logic [3:0] fc;
		logic [2:0] fault;
		logic       taken;
		logic       pv;
		logic [7:0] pc;
		logic       tp;
	} res_t;

	// functions that read an operand from store
	function automatic logic needs_opd(input logic [3:0] f);
		logic r;
		case (f) inside
			F_LDB, F_ADD, F_NADD, F_STQ, F_LDA, F_STA, F_AND,
			F_INC, F_STS, F_MUL, F_DIV: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/acc18_ram.sv
// generic single-port synchronous ram, registered read
// no dependencies
`default_nettype none

module acc18_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 8192
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

`default_nettype wire

FILE: rtl/acc18_div.sv
// iterative restoring divider, one quotient bit per cycle, unsigned magnitudes
// depends on acc18_pkg
`default_nettype none

module acc18_div
	import acc18_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [35:0] dividend,
	input  wire logic [17:0] divisor,
	output div_sts_t         sts,
	output logic      [35:0] quotient
);

	localparam int CNT_W = $clog2(DIV_STEPS + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [17:0]      rem_q;
	logic [35:0]      quo_q;
	logic [17:0]      dvs_q;
	logic [18:0]      shifted;
	logic [19:0]      diff;
	logic             qbit;

	assign shifted = {rem_q, quo_q[35]};
	assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
	assign qbit    = ~diff[19];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[17:0] : shifted[17:0];
			quo_q <= {quo_q[34:0], qbit};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

FILE: rtl/accumulator_cpu_18bit_executor.sv
// 18-bit one-address accumulator processor; store, sequencer and order execution
// an order: sequence update, order read, b-modification, operand read if needed, execute,
// multiply or divide wait, final read, result; write, start: final read; halted: result
// one item in flight, set by the single store port that fetch, modifier, operand and write
// share; the next transfer is taken once the result is loaded, output stalls hold the item
// reset: A, Q and level cleared, machine halted; store contents undefined until written
`default_nettype none

module accumulator_cpu_18bit_executor
	import acc18_pkg::*;
#(
	parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	// address[12:0], data[30:13], reader_char[38:31], zero pad
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,
	// operation[1:0]
	input  wire logic [IN_TUSER_W-1:0]  s_tuser,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// function_code[3:0], fault[6:4], char_taken[7], punch_valid[8], punch_char[16:9],
	// teleprinter[17], acc[35:18], q_value[53:36], next_address[69:54], level[70], pad
	output logic      [OUT_TDATA_W-1:0] m_tdata
);

	localparam int AW = $clog2(STORE_DEPTH);

	typedef enum logic [3:0] {
		S_IDLE, S_WRITE, S_START, S_SC_WR, S_IN_RD, S_IN_DAT, S_MOD,
		S_OP_RD, S_OP_DAT, S_EXEC, S_MUL, S_DIV, S_FIN_RD, S_FIN
	} state_t;

	state_t state_q;

	logic [12:0]          addr_in_q;
	logic [17:0]          data_q;
	logic [7:0]           ch_q;
	logic [17:0]          acc_q;
	logic [17:0]          q_q;
	logic                 lvl_q;
	logic                 halt_q;
	logic [17:0]          scr_q;
	logic [17:0]          instr_q;
	logic [15:0]          m_q;
	logic [17:0]          w_q;
	logic signed [35:0]   prod_q;
	logic                 div_neg_q;
	res_t                 res_q;
	logic [OUT_TDATA_W-1:0] out_q;
	logic                 out_valid_q;

	logic                 ram_we;
	logic [AW-1:0]        ram_addr;
	logic [17:0]          ram_wdata;
	logic [17:0]          ram_rdata;

	logic [AW-1:0]        sc_addr;
	logic [AW-1:0]        bx_addr;
	logic [3:0]           fn;
	logic [15:0]          m_next;
	logic [17:0]          scr1;
	logic                 protect;
	logic                 accept;
	logic                 out_free;

	logic [12:0]          places;
	logic [5:0]           pbits;
	logic [5:0]           lsh;
	logic [5:0]           rsh;
	logic [35:0]          sh_left;
	logic [35:0]          sh_right;

	logic                 div_start;
	logic [35:0]          div_dvd;
	logic [17:0]          div_dvs;
	div_sts_t             div_sts;
	logic [35:0]          div_quo;
	logic [35:0]          quo_signed;

	assign sc_addr  = lvl_q ? AW'(SC_L4) : AW'(SC_L1);
	assign bx_addr  = lvl_q ? AW'(BX_L4) : AW'(BX_L1);
	assign fn       = instr_q[16:13];
	assign scr1     = scr_q + 18'd1;
	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || m_tready;
	assign protect  = !lvl_q && (m_q >= PROTECT_LOW) && (m_q <= PROTECT_HIGH);

	// b-modification uses the modifier word read in the previous cycle
	always_comb begin
		m_next = {scr_q[15:13], instr_q[12:0]};
		if (instr_q[17]) begin
			m_next = m_next + ram_rdata[15:0];
		end
	end

	// double-length shifts
	assign places   = m_q[12:0];
	assign pbits    = places[5:0];
	assign lsh      = (pbits > 6'd48) ? pbits - 6'd16 : pbits;
	assign rsh      = (pbits >= 6'd16) ? 6'(7'd64 - {1'b0, pbits}) : 6'd48 - pbits;
	assign sh_left  = {acc_q, q_q} << lsh;
	assign sh_right = 36'($signed({acc_q, q_q}) >>> rsh);

	assign div_start = (state_q == S_EXEC) && (fn == F_DIV) && (w_q != 18'd0);
	assign div_dvd   = acc_q[17] ? 36'(-{acc_q, q_q}) : {acc_q, q_q};
	assign div_dvs   = w_q[17] ? 18'(-w_q) : w_q;
	assign quo_signed = div_neg_q ? 36'(-div_quo) : div_quo;

	// store port control
	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = sc_addr;
		ram_wdata = acc_q;
		unique case (state_q)
			S_WRITE: begin
				ram_we    = 1'b1;
				ram_addr  = AW'(addr_in_q);
				ram_wdata = data_q;
			end
			S_START: begin
				ram_we    = 1'b1;
				ram_addr  = AW'(SC_L1);
				ram_wdata = 18'(addr_in_q);
			end
			S_SC_WR: begin
				ram_we    = 1'b1;
				ram_wdata = ram_rdata + 18'd1;
			end
			S_IN_RD: begin
				ram_addr = scr_q[AW-1:0];
			end
			S_IN_DAT: begin
				ram_addr = bx_addr;
			end
			S_OP_RD: begin
				ram_addr = m_q[AW-1:0];
			end
			S_EXEC: begin
				ram_addr = m_q[AW-1:0];
				case (fn)
					F_LDB: begin
						ram_we    = 1'b1;
						ram_addr  = bx_addr;
						ram_wdata = w_q;
					end
					F_STQ: begin
						ram_we    = 1'b1;
						ram_wdata = {1'b0, q_q[17:1]};
					end
					F_STA: begin
						ram_we    = !protect;
						ram_wdata = acc_q;
					end
					F_JZ, F_JMP, F_JN: begin
						ram_addr  = sc_addr;
						ram_wdata = {2'b00, m_q};
						ram_we    = (fn == F_JMP) || (fn == F_JZ && acc_q == 18'd0) ||
							(fn == F_JN && acc_q[17]);
					end
					F_INC: begin
						ram_we    = 1'b1;
						ram_wdata = w_q + 18'd1;
					end
					F_STS: begin
						ram_we    = 1'b1;
						ram_wdata = scr1 & ADDR13;
					end
					default: begin
						ram_we = 1'b0;
					end
				endcase
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			acc_q       <= '0;
			q_q         <= '0;
			lvl_q       <= 1'b0;
			halt_q      <= 1'b1;
			out_valid_q <= 1'b0;
			addr_in_q   <= '0;
			data_q      <= '0;
			ch_q        <= '0;
			scr_q       <= '0;
			instr_q     <= '0;
			m_q         <= '0;
			w_q         <= '0;
			prod_q      <= '0;
			div_neg_q   <= 1'b0;
			res_q       <= '0;
			out_q       <= '0;
		end else begin
			if (state_q == S_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						addr_in_q <= s_tdata[12:0];
						data_q    <= s_tdata[30:13];
						ch_q      <= s_tdata[38:31];
						res_q     <= '0;
						if (s_tuser == OP_WRITE) begin
							state_q <= S_WRITE;
						end else if (s_tuser == OP_START) begin
							state_q <= S_START;
						end else if (s_tuser == OP_EXEC && !halt_q) begin
							state_q <= S_SC_WR;
						end else begin
							// store port already reads the sequence register
							state_q <= S_FIN;
						end
					end
				end
				S_WRITE: begin
					state_q <= S_FIN_RD;
				end
				S_START: begin
					acc_q   <= '0;
					q_q     <= '0;
					lvl_q   <= 1'b0;
					halt_q  <= 1'b0;
					state_q <= S_FIN_RD;
				end
				S_SC_WR: begin
					scr_q <= ram_rdata;
					if (ram_rdata >= 18'(STORE_DEPTH)) begin
						res_q.fault <= FLT_ADDR;
						halt_q      <= 1'b1;
						state_q     <= S_FIN_RD;
					end else begin
						state_q <= S_IN_RD;
					end
				end
				S_IN_RD: begin
					state_q <= S_IN_DAT;
				end
				S_IN_DAT: begin
					instr_q  <= ram_rdata;
					res_q.fc <= ram_rdata[16:13];
					state_q  <= S_MOD;
				end
				S_MOD: begin
					m_q <= m_next;
					if (needs_opd(fn)) begin
						if ({1'b0, m_next} >= 17'(STORE_DEPTH)) begin
							res_q.fault <= FLT_ADDR;
							halt_q      <= 1'b1;
							state_q     <= S_FIN_RD;
						end else begin
							state_q <= S_OP_RD;
						end
					end else begin
						state_q <= S_EXEC;
					end
				end
				S_OP_RD: begin
					state_q <= S_OP_DAT;
				end
				S_OP_DAT: begin
					w_q     <= ram_rdata;
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					state_q <= S_FIN_RD;
					case (fn)
						F_LDB: q_q <= w_q;
						F_ADD: acc_q <= acc_q + w_q;
						F_NADD: begin
							q_q   <= w_q;
							acc_q <= w_q - acc_q;
						end
						F_LDA: acc_q <= w_q;
						F_AND: acc_q <= acc_q & w_q;
						F_JMP: q_q <= {2'b00, m_q};
						F_STS: q_q <= scr1 & MOD_BITS;
						F_MUL: begin
							prod_q  <= $signed(acc_q) * $signed(w_q);
							state_q <= S_MUL;
						end
						F_DIV: begin
							if (w_q == 18'd0) begin
								res_q.fault <= FLT_DIV0;
								halt_q      <= 1'b1;
							end else begin
								div_neg_q <= acc_q[17] ^ w_q[17];
								state_q   <= S_DIV;
							end
						end
						F_SHF: begin
							if (places <= SHIFT_L_MAX) begin
								{acc_q, q_q} <= sh_left;
							end else if (places >= SHIFT_R_MIN) begin
								{acc_q, q_q} <= sh_right;
							end else begin
								res_q.fault <= FLT_SHIFT;
								halt_q      <= 1'b1;
							end
						end
						F_IO: begin
							if (places == IO_RD_TAPE || places == IO_RD_TTY) begin
								res_q.taken <= 1'b1;
								res_q.tp    <= (places == IO_RD_TTY);
								acc_q       <= {acc_q[10:0], 7'b0} | {10'b0, ch_q};
							end else if (places == IO_PUN_TAPE || places == IO_PUN_TTY) begin
								res_q.pv <= 1'b1;
								res_q.pc <= acc_q[7:0];
								res_q.tp <= (places == IO_PUN_TTY);
							end else if (places == IO_LEVEL4) begin
								lvl_q <= 1'b1;
							end else begin
								res_q.fault <= FLT_IO;
								halt_q      <= 1'b1;
							end
						end
						default: begin
							// stores, increment and conditional jumps act on the store port only
							acc_q <= acc_q;
						end
					endcase
				end
				S_MUL: begin
					acc_q   <= prod_q[34:17];
					q_q     <= {prod_q[16:0], acc_q[17]};
					state_q <= S_FIN_RD;
				end
				S_DIV: begin
					if (div_sts.done) begin
						acc_q   <= quo_signed[18:1] | 18'd1;
						q_q     <= {quo_signed[18:2], 1'b0};
						state_q <= S_FIN_RD;
					end
				end
				S_FIN_RD: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						out_q <= {1'b0, lvl_q, ram_rdata[15:0], q_q, acc_q, res_q.tp,
							res_q.pc, res_q.pv, res_q.taken, res_q.fault, res_q.fc};
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	acc18_ram #(
		.WIDTH(WORD_W),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	acc18_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dvd),
		.divisor (div_dvs),
		.sts     (div_sts),
		.quotient(div_quo)
	);

	// a faulting item leaves the machine halted when its result is loaded
	a_fault_halts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && res_q.fault != FLT_NONE) |-> halt_q)
		else $error("fault reported without halt");

	// store port never written while waiting for input or output transfer
	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE || state_q == S_FIN) |-> !ram_we)
		else $error("store written outside an item");

	// protected initial orders stay untouched by level one store a
	a_protect: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC && fn == F_STA && ram_we) |-> !protect)
		else $error("store into protected words");

	// divider runs only with a nonzero divisor
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (w_q != 18'd0))
		else $error("divide started by zero");

	// an execute on a halted machine goes straight to the result
	a_halted_skip: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tuser == OP_EXEC && halt_q) |=> (state_q == S_FIN))
		else $error("halted machine executed an order");

endmodule

`default_nettype wire

FILE: dv/tb_accumulator_cpu_18bit_executor.sv
// self-checking testbench of the 18-bit accumulator executor: directed program, then random
// program runs checked against an in-bench predictor; depends on acc18_pkg and the rtl top
`timescale 1ns / 100ps

module tb_accumulator_cpu_18bit_executor
	import acc18_pkg::*;
();

	localparam int DEPTH       = 8192;
	localparam int RAND_ITEMS  = 1350;
	localparam int CYCLE_LIMIT = 5000000;

	typedef struct {
		logic [3:0]  fc;
		logic [2:0]  fault;
		logic        taken;
		logic        pv;
		logic [7:0]  pc;
		logic        tp;
		logic [17:0] acc;
		logic [17:0] q;
		logic [15:0] seq;
		logic        lvl;
	} cpu_res_t;

	typedef struct {
		logic [1:0]  op;
		logic [12:0] addr;
		logic [7:0]  ch;
		bit          has_flt;
		logic [2:0]  flt;
	} dir_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic [IN_TUSER_W-1:0]  s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;

	accumulator_cpu_18bit_executor dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// predictor state
	logic [17:0] shadow_store [DEPTH];
	logic [17:0] shadow_acc, shadow_q;
	logic        shadow_lvl4, shadow_halt;

	cpu_res_t    pending_results [$];
	int          mismatch_count = 0;
	int          cycles = 0;
	int          burst_left = 0;
	dir_row_t    dir_rows [$];
	logic [17:0] boot_image [int];

	initial clk = 1'b0;

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_accumulator_cpu_18bit_executor: FAIL");
			$finish;
		end
	end

	function automatic logic [17:0] order_word(input bit modf, input logic [3:0] f,
			input int ad);
		return {modf, f, ad[12:0]};
	endfunction

	function automatic longint sx18(input logic [17:0] v);
		return longint'($signed(v));
	endfunction

	task automatic run_order(input logic [7:0] ch, inout cpu_res_t r, output logic [2:0] flt);
		logic [2:0]  sc, bx;
		logic [17:0] scr, instr, a, w;
		logic [15:0] m;
		logic [12:0] z;
		logic [3:0]  f;
		logic [63:0] aq;
		longint      al, wl, prod, quot;
		int          p;
		flt = FLT_NONE;
		sc = shadow_lvl4 ? SC_L4 : SC_L1;
		bx = shadow_lvl4 ? BX_L4 : BX_L1;
		scr = shadow_store[sc];
		shadow_store[sc] = scr + 18'd1;
		if (scr >= DEPTH) begin
			flt = FLT_ADDR;
			return;
		end
		instr = shadow_store[scr[12:0]];
		f = instr[16:13];
		r.fc = f;
		a = (instr & ADDR13) | (scr & MOD_BITS);
		m = instr[17] ? 16'(a + shadow_store[bx]) : a[15:0];
		w = '0;
		if (f <= F_AND || (f >= F_INC && f <= F_DIV)) begin
			if (m >= DEPTH) begin
				flt = FLT_ADDR;
				return;
			end
			w = shadow_store[m[12:0]];
		end
		z = m[12:0];
		case (f)
			F_LDB: begin
				shadow_q = w;
				shadow_store[bx] = w;
			end
			F_ADD:  shadow_acc = shadow_acc + w;
			F_NADD: begin
				shadow_q = w;
				shadow_acc = w - shadow_acc;
			end
			F_STQ: shadow_store[z] = shadow_q >> 1;
			F_LDA: shadow_acc = w;
			F_STA: begin
				// initial orders are write-protected at level one
				if (!(!shadow_lvl4 && m >= PROTECT_LOW && m <= PROTECT_HIGH))
					shadow_store[z] = shadow_acc;
			end
			F_AND: shadow_acc = shadow_acc & w;
			F_JZ:  if (shadow_acc == 0) shadow_store[sc] = {2'b0, m};
			F_JMP: begin
				shadow_store[sc] = {2'b0, m};
				shadow_q = {2'b0, m};
			end
			F_JN:  if (shadow_acc[17]) shadow_store[sc] = {2'b0, m};
			F_INC: shadow_store[z] = w + 18'd1;
			F_STS: begin
				shadow_q = shadow_store[sc] & MOD_BITS;
				shadow_store[z] = shadow_store[sc] & ADDR13;
			end
			F_MUL: begin
				al = sx18(shadow_acc);
				wl = sx18(w);
				prod = al * wl;
				shadow_q = {prod[16:0], 1'b0} | {17'b0, al < 0};
				shadow_acc = prod[34:17];
			end
			F_DIV: begin
				wl = sx18(w);
				if (wl == 0) begin
					flt = FLT_DIV0;
					return;
				end
				al = sx18(shadow_acc) * 262144 + longint'({46'b0, shadow_q});
				quot = al / wl;
				shadow_acc = quot[18:1] | 18'd1;
				shadow_q = quot[18:1] & 18'o777776;
			end
			F_SHF: begin
				p = int'(z[5:0]);
				aq = {{28{shadow_acc[17]}}, shadow_acc, shadow_q};
				if (z <= SHIFT_L_MAX) begin
					if (p > 48) p -= 16;
					aq = aq << p;
				end else if (z >= SHIFT_R_MIN) begin
					p = (p >= 16) ? 64 - p : 48 - p;
					aq = $signed(aq) >>> p;
				end else begin
					flt = FLT_SHIFT;
					return;
				end
				shadow_q = aq[17:0];
				shadow_acc = aq[35:18];
			end
			default: begin
				if (z == IO_RD_TAPE || z == IO_RD_TTY) begin
					r.taken = 1'b1;
					r.tp = (z == IO_RD_TTY);
					shadow_acc = {shadow_acc[10:0], 7'b0} | {10'b0, ch};
				end else if (z == IO_PUN_TAPE || z == IO_PUN_TTY) begin
					r.pv = 1'b1;
					r.pc = shadow_acc[7:0];
					r.tp = (z == IO_PUN_TTY);
				end else if (z == IO_LEVEL4) begin
					shadow_lvl4 = 1'b1;
				end else begin
					flt = FLT_IO;
				end
			end
		endcase
	endtask

	task automatic predict_step(input logic [1:0] op, input logic [12:0] ad,
			input logic [17:0] dt, input logic [7:0] ch, output cpu_res_t r);
		logic [2:0] flt;
		r = '{default: '0};
		flt = FLT_NONE;
		if (op == OP_WRITE) begin
			shadow_store[ad] = dt;
		end else if (op == OP_START) begin
			shadow_acc = '0;
			shadow_q = '0;
			shadow_lvl4 = 1'b0;
			shadow_store[SC_L1] = {5'b0, ad};
			shadow_halt = 1'b0;
		end else if (op == OP_EXEC && !shadow_halt) begin
			run_order(ch, r, flt);
			if (flt != FLT_NONE) shadow_halt = 1'b1;
		end
		r.fault = flt;
		r.acc = shadow_acc;
		r.q = shadow_q;
		r.seq = shadow_store[shadow_lvl4 ? SC_L4 : SC_L1][15:0];
		r.lvl = shadow_lvl4;
	endtask

	// predicts, queues the expectation, then moves one item across the input side
	task automatic send_item(input logic [1:0] op, input logic [12:0] ad,
			input logic [17:0] dt, input logic [7:0] ch, input bit has_flt = 0,
			input logic [2:0] flt = FLT_NONE);
		cpu_res_t r;
		predict_step(op, ad, dt, ch, r);
		if (has_flt) r.fault = flt;
		pending_results.push_back(r);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 10);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {1'b0, ch, dt, ad};
		forever begin
			@(negedge clk);
			if (s_tready) break;
		end
		@(posedge clk);
		burst_left--;
	endtask

	task automatic report(input string what, input logic [17:0] got, input logic [17:0] want);
		$display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
		mismatch_count++;
	endtask

	// result monitor: a transfer seen at the falling edge completes at the next rising edge
	always @(negedge clk) begin
		cpu_res_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report("unexpected transfer", m_tdata[17:0], '0);
			end else begin
				e = pending_results.pop_front();
				if (m_tdata[3:0]   != e.fc)    report("function_code", m_tdata[3:0], e.fc);
				if (m_tdata[6:4]   != e.fault) report("fault", m_tdata[6:4], e.fault);
				if (m_tdata[7]     != e.taken) report("char_taken", m_tdata[7], e.taken);
				if (m_tdata[8]     != e.pv)    report("punch_valid", m_tdata[8], e.pv);
				if (m_tdata[16:9]  != e.pc)    report("punch_char", m_tdata[16:9], e.pc);
				if (m_tdata[17]    != e.tp)    report("teleprinter", m_tdata[17], e.tp);
				if (m_tdata[35:18] != e.acc)   report("acc", m_tdata[35:18], e.acc);
				if (m_tdata[53:36] != e.q)     report("q_value", m_tdata[53:36], e.q);
				if (m_tdata[69:54] != e.seq)   report("next_address", m_tdata[69:54], e.seq);
				if (m_tdata[70]    != e.lvl)   report("level", m_tdata[70], e.lvl);
			end
		end
	end

	// receiver stall pattern: m_tready follows a random 16-bit pattern, redrawn when pat_cnt runs out
	initial begin
		logic [15:0] pat;
		int          pat_cnt;
		pat_cnt = 0;
		pat = '1;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (pat_cnt == 0) begin
				pat = ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom);
				pat_cnt = 64;
			end
			m_tready <= pat[pat_cnt % 16];
			pat_cnt--;
		end
	end

	function automatic logic [17:0] random_order(input int lo, input int hi);
		logic [3:0] f;
		int         ad;
		int         sel;
		f = 4'($urandom_range(0, 15));
		sel = $urandom_range(0, 15);
		case (f)
			F_JZ, F_JMP, F_JN: ad = $urandom_range(lo, hi);
			F_SHF: begin
				if (sel == 0) ad = $urandom_range(2048, 6143);
				else if (sel < 8) ad = $urandom_range(0, 2047);
				else ad = $urandom_range(6144, 8191);
			end
			F_IO: begin
				if (sel == 0) ad = $urandom_range(0, 8191);
				else case (sel % 5)
					0: ad = IO_RD_TAPE;
					1: ad = IO_RD_TTY;
					2: ad = IO_PUN_TAPE;
					3: ad = IO_PUN_TTY;
					default: ad = IO_LEVEL4;
				endcase
			end
			default: ad = (sel < 12) ? $urandom_range(lo, hi + 16) : $urandom_range(0, 8191);
		endcase
		return order_word($urandom_range(0, 7) == 0, f, ad);
	endfunction

	initial begin
		int       items;
		int       base;
		int       n;
		dir_row_t row;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_WRITE;
		shadow_acc = '0;
		shadow_q = '0;
		shadow_lvl4 = 1'b0;
		shadow_halt = 1'b1;

		// directed program at 100, fault cases from 130, operands from 200
		boot_image[100] = order_word(0, F_LDA, 200);
		boot_image[101] = order_word(0, F_ADD, 201);
		boot_image[102] = order_word(0, F_JZ, 104);
		boot_image[103] = order_word(0, F_JMP, 104);
		boot_image[104] = order_word(0, F_NADD, 200);
		boot_image[105] = order_word(0, F_STQ, 202);
		boot_image[106] = order_word(0, F_STA, 8185);
		boot_image[107] = order_word(0, F_AND, 200);
		boot_image[108] = order_word(0, F_INC, 202);
		boot_image[109] = order_word(0, F_STS, 203);
		boot_image[110] = order_word(0, F_MUL, 200);
		boot_image[111] = order_word(0, F_DIV, 201);
		boot_image[112] = order_word(0, F_SHF, 6149);
		boot_image[113] = order_word(0, F_SHF, 50);
		boot_image[114] = order_word(0, F_JN, 116);
		boot_image[115] = order_word(0, F_JMP, 116);
		boot_image[116] = order_word(0, F_IO, IO_RD_TAPE);
		boot_image[117] = order_word(0, F_IO, IO_PUN_TTY);
		boot_image[118] = order_word(0, F_LDB, 201);
		boot_image[119] = order_word(1, F_LDA, 199);
		boot_image[120] = order_word(0, F_JMP, 122);
		boot_image[122] = order_word(0, F_IO, IO_LEVEL4);
		boot_image[130] = order_word(0, F_DIV, 204);
		boot_image[131] = order_word(0, F_SHF, 3000);
		boot_image[132] = order_word(0, F_IO, 100);
		boot_image[133] = order_word(1, F_LDA, 8191);
		boot_image[134] = order_word(1, F_JMP, 8191);
		boot_image[200] = 18'o777777;
		boot_image[201] = 18'd1;
		boot_image[204] = 18'd0;

		dir_rows.push_back('{OP_EXEC, 13'd0, 8'h00, 1, FLT_NONE});
		dir_rows.push_back('{2'd3, 13'h1fff, 8'hff, 1, FLT_NONE});
		dir_rows.push_back('{OP_START, 13'd100, 8'h00, 0, FLT_NONE});
		for (int i = 0; i < 20; i++)
			dir_rows.push_back('{OP_EXEC, 13'd0, (i == 16) ? 8'hff : 8'($urandom), 0, FLT_NONE});
		dir_rows.push_back('{OP_START, 13'd130, 8'h00, 0, FLT_NONE});
		dir_rows.push_back('{OP_EXEC, 13'd0, 8'h00, 1, FLT_DIV0});
		dir_rows.push_back('{OP_START, 13'd131, 8'h00, 0, FLT_NONE});
		dir_rows.push_back('{OP_EXEC, 13'd0, 8'h00, 1, FLT_SHIFT});
		dir_rows.push_back('{OP_START, 13'd132, 8'h00, 0, FLT_NONE});
		dir_rows.push_back('{OP_EXEC, 13'd0, 8'h00, 1, FLT_IO});
		dir_rows.push_back('{OP_START, 13'd133, 8'h00, 0, FLT_NONE});
		dir_rows.push_back('{OP_EXEC, 13'd0, 8'h00, 1, FLT_ADDR});
		dir_rows.push_back('{OP_START, 13'd134, 8'h00, 0, FLT_NONE});
		dir_rows.push_back('{OP_EXEC, 13'd0, 8'h00, 1, FLT_NONE});
		dir_rows.push_back('{OP_EXEC, 13'd0, 8'h00, 1, FLT_ADDR});
		dir_rows.push_back('{OP_EXEC, 13'd0, 8'h00, 1, FLT_NONE});

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every word is written once so that no order can read an undefined word
		for (int a = 0; a < DEPTH; a++)
			send_item(OP_WRITE, 13'(a), boot_image.exists(a) ? boot_image[a] : 18'($urandom),
				8'($urandom));

		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			send_item(row.op, row.addr, 18'($urandom), row.ch, row.has_flt, row.flt);
		end

		// random programs: load a block of orders, start on it, then step through it
		items = 0;
		while (items < RAND_ITEMS) begin
			base = $urandom_range(8, 8100);
			for (int i = 0; i < 24; i++)
				send_item(OP_WRITE, 13'(base + i), random_order(base, base + 23), 8'($urandom));
			if ($urandom_range(0, 1) == 0)
				send_item(OP_WRITE, 13'(BX_L1), 18'($urandom_range(0, 200)), 8'($urandom));
			if ($urandom_range(0, 2) == 0)
				send_item(OP_WRITE, 13'(SC_L4), 18'(base + $urandom_range(0, 23)), 8'($urandom));
			if ($urandom_range(0, 2) == 0)
				send_item(OP_WRITE, 13'(BX_L4), 18'($urandom_range(0, 200)), 8'($urandom));
			for (int i = 0; i < 8; i++)
				send_item(OP_WRITE, 13'(base + 24 + i), 18'($urandom), 8'($urandom));
			send_item(OP_START, 13'(base), 18'($urandom), 8'($urandom));
			n = $urandom_range(10, 30);
			for (int i = 0; i < n; i++) begin
				case ($urandom_range(0, 19))
					0: send_item(2'd3, 13'($urandom), 18'($urandom), 8'($urandom));
					1: send_item(OP_WRITE, 13'($urandom_range(base + 24, base + 40)),
						18'($urandom), 8'($urandom));
					default: send_item(OP_EXEC, 13'($urandom), 18'($urandom), 8'($urandom));
				endcase
			end
			items += n + 33;
		end
		s_tvalid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb_accumulator_cpu_18bit_executor: PASS");
		else
			$display("tb_accumulator_cpu_18bit_executor: FAIL");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/acc18_pkg.sv
rtl/acc18_ram.sv
rtl/acc18_div.sv
rtl/accumulator_cpu_18bit_executor.sv
dv/tb_accumulator_cpu_18bit_executor.sv
